FILE: rtl/wsp_pkg.sv
// Shared types and constants for the WAV stream parser.
// Used by the controller, the datapath and the top level.
`default_nettype none

package wsp_pkg;

	// Default number of channels that a frame may hold.
	localparam int MAX_CHANNELS = 8;

	// Chunk tags, read as big-endian words of the four ASCII characters.
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;

	// Format requirements checked at the data chunk; the size minimum is checked at the fmt chunk.
	localparam logic [15:0] FORMAT_PCM   = 16'd1;
	localparam logic [15:0] BITS_PCM16   = 16'd16;
	localparam logic [31:0] FMT_MIN_SIZE = 32'd16;

	// Byte positions within the fixed header pieces.
	localparam logic [3:0] PRE_LAST_BYTE = 4'd11;
	localparam logic [3:0] HDR_LAST_BYTE = 4'd7;
	localparam logic [3:0] WAVE_FIRST    = 4'd8;
	localparam logic [3:0] RIFF_END      = 4'd4;

	// Byte offsets of the fields inside a fmt chunk.
	localparam logic [4:0] FMT_OFS_FORMAT_LO = 5'd0;
	localparam logic [4:0] FMT_OFS_FORMAT_HI = 5'd1;
	localparam logic [4:0] FMT_OFS_CHAN_LO   = 5'd2;
	localparam logic [4:0] FMT_OFS_CHAN_HI   = 5'd3;
	localparam logic [4:0] FMT_OFS_RATE_0    = 5'd4;
	localparam logic [4:0] FMT_OFS_RATE_1    = 5'd5;
	localparam logic [4:0] FMT_OFS_RATE_2    = 5'd6;
	localparam logic [4:0] FMT_OFS_RATE_3    = 5'd7;
	localparam logic [4:0] FMT_OFS_BITS_LO   = 5'd14;
	localparam logic [4:0] FMT_OFS_BITS_HI   = 5'd15;
	localparam logic [4:0] FMT_OFS_END       = 5'd16;

	// Kind of a result request.
	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_SAMPLE = 2'd1,
		KIND_END    = 2'd2,
		KIND_ERROR  = 2'd3
	} result_kind_t;

	// Error code carried with an error result.
	typedef enum logic {
		ERR_PROTOCOL = 1'b0,
		ERR_FORMAT   = 1'b1
	} error_code_t;

	// Value of the action field.
	typedef enum logic {
		ACT_BYTE = 1'b0,
		ACT_END  = 1'b1
	} action_t;

	// Datapath operation for the current cycle.
	typedef enum logic [2:0] {
		DP_NOP  = 3'd0,
		DP_PRE  = 3'd1,
		DP_HDR  = 3'd2,
		DP_FMT  = 3'd3,
		DP_SKIP = 3'd4,
		DP_DATA = 3'd5,
		DP_EMIT = 3'd6
	} dp_op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		dp_op_t       op;
		logic         push;
		result_kind_t kind;
		error_code_t  code;
	} wsp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
		logic pre_last;
		logic pre_ok;
		logic hdr_last;
		logic tag_fmt;
		logic tag_data;
		logic size_small;
		logic size_zero;
		logic size_odd;
		logic fmt_ok;
		logic left_last;
		logic chunk_odd;
		logic frame_empty;
		logic frame_last;
		logic emit_last;
	} wsp_status_t;

	// Expected preamble byte at a given position (RIFF, then WAVE).
	function automatic logic [7:0] preamble_byte(input logic [3:0] pos);
		logic [7:0] val;
		case (pos)
			4'd0:    val = 8'h52;
			4'd1:    val = 8'h49;
			4'd2:    val = 8'h46;
			4'd3:    val = 8'h46;
			4'd8:    val = 8'h57;
			4'd9:    val = 8'h41;
			4'd10:   val = 8'h56;
			4'd11:   val = 8'h45;
			default: val = 8'h00;
		endcase
		return val;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/wsp_if.sv
// Valid/ready channel interfaces of the WAV stream parser.
// Depends on nothing but itself; field widths are fixed by the stream format.
`default_nettype none

// Input channel: one stream byte or an end-of-stream mark per request.
interface wsp_stream_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] stream_byte;

	modport source (output valid, output action, output stream_byte, input ready);
	modport sink (input valid, input action, input stream_byte, output ready);
endinterface

// Output channel: one header, sample, end or error result per request.
interface wsp_result_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  result_kind;
	logic               error_code;
	logic signed [15:0] sample_value;
	logic        [2:0]  channel_index;
	logic               frame_end;
	logic        [31:0] sample_rate;
	logic        [3:0]  channel_count;

	modport source (
		output valid, output result_kind, output error_code, output sample_value,
		output channel_index, output frame_end, output sample_rate,
		output channel_count, input ready
	);
	modport sink (
		input valid, input result_kind, input error_code, input sample_value,
		input channel_index, input frame_end, input sample_rate,
		input channel_count, output ready
	);
endinterface

`default_nettype wire

FILE: rtl/wsp_ctrl.sv
// Parser controller: walks preamble, chunk headers, fmt, skip, pad, data and emit phases.
// Depends on wsp_pkg for the command and status types.
`default_nettype none

module wsp_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	input  wire                  action,
	output logic                 in_ready,
	input  wsp_pkg::wsp_status_t status,
	output wsp_pkg::wsp_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_PRE,
		ST_HDR,
		ST_FMT,
		ST_SKIP,
		ST_PAD,
		ST_DATA,
		ST_EMIT,
		ST_DONE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   fire;

	// A request is taken whenever the result register can take a result and no frame is being emitted.
	assign in_ready = status.out_free && (state_q != ST_EMIT);
	assign fire     = in_valid && in_ready;

	// Next state and datapath command.
	always_comb begin
		state_d   = state_q;
		cmd.op    = wsp_pkg::DP_NOP;
		cmd.push  = 1'b0;
		cmd.kind  = wsp_pkg::KIND_ERROR;
		cmd.code  = wsp_pkg::ERR_PROTOCOL;
		if (state_q == ST_EMIT) begin
			// Drain the gathered frame one sample per free output slot.
			if (status.out_free) begin
				cmd.op   = wsp_pkg::DP_EMIT;
				cmd.push = 1'b1;
				cmd.kind = wsp_pkg::KIND_SAMPLE;
				if (status.emit_last) begin
					state_d = ST_DATA;
				end
			end
		end else if (fire && state_q != ST_DONE) begin
			if (action == wsp_pkg::ACT_END) begin
				// End of stream is clean only between frames of the data.
				cmd.push = 1'b1;
				state_d  = ST_DONE;
				if (state_q == ST_DATA && status.frame_empty) begin
					cmd.kind = wsp_pkg::KIND_END;
				end
			end else begin
				case (state_q)
					ST_PRE: begin
						cmd.op = wsp_pkg::DP_PRE;
						if (status.pre_last) begin
							if (status.pre_ok) begin
								state_d = ST_HDR;
							end else begin
								cmd.push = 1'b1;
								state_d  = ST_DONE;
							end
						end
					end
					ST_HDR: begin
						cmd.op = wsp_pkg::DP_HDR;
						if (status.hdr_last) begin
							if (status.tag_fmt) begin
								if (status.size_small) begin
									cmd.push = 1'b1;
									state_d  = ST_DONE;
								end else begin
									state_d = ST_FMT;
								end
							end else if (status.tag_data) begin
								cmd.push = 1'b1;
								if (status.fmt_ok) begin
									cmd.kind = wsp_pkg::KIND_HEADER;
									state_d  = ST_DATA;
								end else begin
									cmd.code = wsp_pkg::ERR_FORMAT;
									state_d  = ST_DONE;
								end
							end else if (status.size_zero) begin
								state_d = status.size_odd ? ST_PAD : ST_HDR;
							end else begin
								state_d = ST_SKIP;
							end
						end
					end
					ST_FMT, ST_SKIP: begin
						cmd.op = (state_q == ST_FMT) ? wsp_pkg::DP_FMT : wsp_pkg::DP_SKIP;
						if (status.left_last) begin
							state_d = status.chunk_odd ? ST_PAD : ST_HDR;
						end
					end
					ST_PAD: begin
						state_d = ST_HDR;
					end
					ST_DATA: begin
						cmd.op = wsp_pkg::DP_DATA;
						if (status.frame_last) begin
							state_d = ST_EMIT;
						end
					end
					default: begin
						state_d = state_q;
					end
				endcase
			end
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_PRE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/wsp_dp.sv
// Parser datapath: header fields, chunk counters, frame store and result register.
// Depends on wsp_pkg for constants and the command and status types.
`default_nettype none

module wsp_dp #(
	parameter int MAX_CHANNELS = wsp_pkg::MAX_CHANNELS
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire        [7:0]           stream_byte,
	input  wsp_pkg::wsp_cmd_t          cmd,
	output wsp_pkg::wsp_status_t       status,
	input  wire                        out_ready,
	output logic                       out_valid,
	output logic       [1:0]           out_kind,
	output logic                       out_code,
	output logic signed [15:0]         out_sample,
	output logic       [2:0]           out_channel,
	output logic                       out_frame_end,
	output logic       [31:0]          out_rate,
	output logic       [3:0]           out_count
);

	localparam int IdxW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int ChW  = $clog2(MAX_CHANNELS + 1);
	localparam int PosW = $clog2(2 * MAX_CHANNELS + 1);

	logic [3:0]       byte_cnt_q;
	logic             preamble_ok_q;
	logic [31:0]      chunk_tag_q;
	logic [31:0]      chunk_left_q;
	logic             chunk_odd_q;
	logic [4:0]       fmt_offset_q;
	logic [15:0]      format_code_q;
	logic [15:0]      channel_field_q;
	logic [31:0]      rate_field_q;
	logic [15:0]      bits_field_q;
	logic [7:0]       low_byte_q;
	logic [PosW-1:0]  frame_pos_q;
	logic [IdxW-1:0]  emit_idx_q;
	logic [15:0]      frame_store [MAX_CHANNELS];

	logic             out_valid_q;
	logic [1:0]       out_kind_q;
	logic             out_code_q;
	logic [15:0]      out_sample_q;
	logic [2:0]       out_channel_q;
	logic             out_frame_end_q;
	logic [31:0]      out_rate_q;
	logic [3:0]       out_count_q;

	logic             pre_mismatch;
	logic [31:0]      size_full;
	logic [ChW-1:0]   nch;
	logic [PosW:0]    pos_next;

	// Preamble byte check against RIFF at the front and WAVE at the back.
	assign pre_mismatch = ((byte_cnt_q < wsp_pkg::RIFF_END) ||
		(byte_cnt_q >= wsp_pkg::WAVE_FIRST)) &&
		(stream_byte != wsp_pkg::preamble_byte(byte_cnt_q));

	// The chunk size as it stands once the current byte is shifted in.
	assign size_full = {stream_byte, chunk_left_q[31:8]};
	assign nch       = channel_field_q[ChW-1:0];
	assign pos_next  = {1'b0, frame_pos_q} + (PosW + 1)'(1);

	// Status toward the controller.
	always_comb begin
		status.out_free    = !out_valid_q || out_ready;
		status.pre_last    = (byte_cnt_q == wsp_pkg::PRE_LAST_BYTE);
		status.pre_ok      = preamble_ok_q && !pre_mismatch;
		status.hdr_last    = (byte_cnt_q == wsp_pkg::HDR_LAST_BYTE);
		status.tag_fmt     = (chunk_tag_q == wsp_pkg::TAG_FMT);
		status.tag_data    = (chunk_tag_q == wsp_pkg::TAG_DATA);
		status.size_small  = (size_full < wsp_pkg::FMT_MIN_SIZE);
		status.size_zero   = (size_full == 32'd0);
		status.size_odd    = size_full[0];
		status.fmt_ok      = (format_code_q == wsp_pkg::FORMAT_PCM) &&
			(channel_field_q != 16'd0) &&
			(channel_field_q <= 16'(MAX_CHANNELS)) &&
			(rate_field_q != 32'd0) && (bits_field_q == wsp_pkg::BITS_PCM16);
		status.left_last   = (chunk_left_q == 32'd1);
		status.chunk_odd   = chunk_odd_q;
		status.frame_empty = (frame_pos_q == '0);
		status.frame_last  = (pos_next == {1'b0, nch, 1'b0});
		status.emit_last   = (emit_idx_q == IdxW'(nch - ChW'(1)));
	end

	// Header and framing control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_cnt_q    <= '0;
			preamble_ok_q <= 1'b1;
			chunk_odd_q   <= 1'b0;
			fmt_offset_q  <= '0;
			frame_pos_q   <= '0;
			emit_idx_q    <= '0;
		end else begin
			case (cmd.op)
				wsp_pkg::DP_PRE: begin
					if (pre_mismatch) begin
						preamble_ok_q <= 1'b0;
					end
					byte_cnt_q <= (byte_cnt_q == wsp_pkg::PRE_LAST_BYTE) ? 4'd0 :
						byte_cnt_q + 4'd1;
				end
				wsp_pkg::DP_HDR: begin
					if (byte_cnt_q == wsp_pkg::HDR_LAST_BYTE) begin
						byte_cnt_q   <= 4'd0;
						chunk_odd_q  <= size_full[0];
						fmt_offset_q <= '0;
						frame_pos_q  <= '0;
						emit_idx_q   <= '0;
					end else begin
						byte_cnt_q <= byte_cnt_q + 4'd1;
					end
				end
				wsp_pkg::DP_FMT: begin
					if (fmt_offset_q != wsp_pkg::FMT_OFS_END) begin
						fmt_offset_q <= fmt_offset_q + 5'd1;
					end
				end
				wsp_pkg::DP_DATA: begin
					frame_pos_q <= status.frame_last ? '0 : pos_next[PosW-1:0];
				end
				wsp_pkg::DP_EMIT: begin
					emit_idx_q <= status.emit_last ? '0 : emit_idx_q + IdxW'(1);
				end
				default: begin
					byte_cnt_q <= byte_cnt_q;
				end
			endcase
		end
	end

	// Chunk tag, size counter and fmt fields; the fmt fields start out as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_tag_q     <= '0;
			chunk_left_q    <= '0;
			format_code_q   <= '0;
			channel_field_q <= '0;
			rate_field_q    <= '0;
			bits_field_q    <= '0;
		end else begin
			case (cmd.op)
				wsp_pkg::DP_HDR: begin
					if (byte_cnt_q < wsp_pkg::RIFF_END) begin
						chunk_tag_q <= {chunk_tag_q[23:0], stream_byte};
					end else begin
						chunk_left_q <= size_full;
					end
				end
				wsp_pkg::DP_FMT: begin
					chunk_left_q <= chunk_left_q - 32'd1;
					case (fmt_offset_q)
						wsp_pkg::FMT_OFS_FORMAT_LO: format_code_q <= {8'd0, stream_byte};
						wsp_pkg::FMT_OFS_FORMAT_HI: format_code_q[15:8] <= stream_byte;
						wsp_pkg::FMT_OFS_CHAN_LO: channel_field_q <= {8'd0, stream_byte};
						wsp_pkg::FMT_OFS_CHAN_HI: channel_field_q[15:8] <= stream_byte;
						wsp_pkg::FMT_OFS_RATE_0: rate_field_q <= {24'd0, stream_byte};
						wsp_pkg::FMT_OFS_RATE_1: rate_field_q[15:8] <= stream_byte;
						wsp_pkg::FMT_OFS_RATE_2: rate_field_q[23:16] <= stream_byte;
						wsp_pkg::FMT_OFS_RATE_3: rate_field_q[31:24] <= stream_byte;
						wsp_pkg::FMT_OFS_BITS_LO: bits_field_q <= {8'd0, stream_byte};
						wsp_pkg::FMT_OFS_BITS_HI: bits_field_q[15:8] <= stream_byte;
						default: begin
							bits_field_q <= bits_field_q;
						end
					endcase
				end
				wsp_pkg::DP_SKIP: begin
					chunk_left_q <= chunk_left_q - 32'd1;
				end
				default: begin
					chunk_left_q <= chunk_left_q;
				end
			endcase
		end
	end

	// Frame store: the low byte is held, the high byte completes the sample.
	always_ff @(posedge clk) begin
		if (cmd.op == wsp_pkg::DP_DATA) begin
			if (!frame_pos_q[0]) begin
				low_byte_q <= stream_byte;
			end else begin
				frame_store[IdxW'(frame_pos_q >> 1)] <= {stream_byte, low_byte_q};
			end
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload; samples are read from the frame store here.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_kind_q      <= cmd.kind;
			out_code_q      <= (cmd.kind == wsp_pkg::KIND_ERROR) ? cmd.code :
				wsp_pkg::ERR_PROTOCOL;
			out_sample_q    <= '0;
			out_channel_q   <= '0;
			out_frame_end_q <= 1'b0;
			out_rate_q      <= '0;
			out_count_q     <= '0;
			if (cmd.kind == wsp_pkg::KIND_SAMPLE) begin
				out_sample_q    <= frame_store[emit_idx_q];
				out_channel_q   <= 3'(emit_idx_q);
				out_frame_end_q <= status.emit_last;
			end
			if (cmd.kind == wsp_pkg::KIND_HEADER) begin
				out_rate_q  <= rate_field_q;
				out_count_q <= channel_field_q[3:0];
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign out_kind      = out_kind_q;
	assign out_code      = out_code_q;
	assign out_sample    = out_sample_q;
	assign out_channel   = out_channel_q;
	assign out_frame_end = out_frame_end_q;
	assign out_rate      = out_rate_q;
	assign out_count     = out_count_q;

endmodule

`default_nettype wire

FILE: rtl/wav_stream_parser.sv
// WAV stream parser top level: joins the controller and the datapath to the channels.
// Depends on wsp_pkg, wsp_if (wsp_stream_if, wsp_result_if), wsp_ctrl and wsp_dp.
//
// Usage: the stream channel carries one byte of a RIFF/WAV file per request,
// or an end-of-stream mark (action high). The result channel returns the
// header report (rate and channel count) once the data chunk is reached,
// then the samples of each complete frame, channel by channel, and finally
// a clean-end or error result. After an end or error, further requests are
// taken and dropped without results.
// Header, end and error results are presented in the cycle after the request
// that causes them. One byte per cycle is taken through the header and within
// a frame while the output register is free; after the last byte of a frame
// the stream side is held off while the samples are read out of the frame
// store, one per cycle while the output register is free.
// Stalls: results wait in a single output register; a new request is taken
// only when that register is empty or being drained in the same cycle, and
// not while samples are read out. Reset (arst_n low) clears the controller,
// the counters and the output valid flag; then the 12-byte preamble is expected.
`default_nettype none

module wav_stream_parser #(
	parameter int MAX_CHANNELS = wsp_pkg::MAX_CHANNELS
) (
	input  wire                 clk,
	input  wire                 arst_n,
	wsp_stream_if.sink          stream,
	wsp_result_if.source        result
);

	wsp_pkg::wsp_cmd_t    cmd;
	wsp_pkg::wsp_status_t status;

	// Phase sequencing.
	wsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (stream.valid),
		.action   (stream.action),
		.in_ready (stream.ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Fields, counters, frame store and result register.
	wsp_dp #(
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.stream_byte   (stream.stream_byte),
		.cmd           (cmd),
		.status        (status),
		.out_ready     (result.ready),
		.out_valid     (result.valid),
		.out_kind      (result.result_kind),
		.out_code      (result.error_code),
		.out_sample    (result.sample_value),
		.out_channel   (result.channel_index),
		.out_frame_end (result.frame_end),
		.out_rate      (result.sample_rate),
		.out_count     (result.channel_count)
	);

endmodule

`default_nettype wire

FILE: verif/tb_wav_stream_parser.sv
// Self-checking testbench for wav_stream_parser: feeds one RIFF/WAV byte stream and checks
// every result request against a predictor kept inside the testbench.
// Depends on wsp_pkg, wav_stream_parser and the wsp_stream_if / wsp_result_if interfaces.
`default_nettype none

module tb_wav_stream_parser;

	localparam int LIMIT_CYCLES = 200000;
	localparam int TAIL_CYCLES  = 20;
	localparam int LONG_STALL   = 300;
	localparam int CHAN_LIMIT   = 8;

	localparam logic [31:0] RIFF_WORD  = "RIFF";
	localparam logic [31:0] WAVE_WORD  = "WAVE";
	localparam logic [31:0] FMT_WORD   = "fmt ";
	localparam logic [31:0] DATA_WORD  = "data";
	localparam logic [15:0] PCM_FORMAT = 16'd1;
	localparam logic [15:0] PCM_BITS   = 16'd16;
	localparam logic [31:0] FMT_BODY   = 32'd16;

	// Full-scale positive, full-scale negative, zero and minus one.
	localparam logic [63:0] SAMPLE_EXTREMES = 64'h7FFF_8000_0000_FFFF;

	// Parser phases of the predictor.
	typedef enum logic [2:0] {
		ST_PREAMBLE, ST_HEADER, ST_FMT, ST_SKIP, ST_PAD, ST_DATA, ST_DONE, ST_FAILED
	} parse_phase_t;

	// How the stream of this run goes wrong, if at all.
	typedef enum int {
		FAULT_NONE, FAULT_PREAMBLE, FAULT_SHORT_FMT, FAULT_NO_FMT, FAULT_FORMAT,
		FAULT_TRUNCATED
	} stream_fault_t;

	// Idle pattern: sender rarely idle, then receiver rarely idle, then no idling.
	typedef enum int {
		GAPS_RECEIVER_SLOW, GAPS_SENDER_SLOW, GAPS_NONE
	} gap_mode_t;

	typedef struct packed {
		wsp_pkg::action_t act;
		logic [7:0]       b;
	} stream_req_t;

	typedef struct packed {
		wsp_pkg::result_kind_t kind;
		wsp_pkg::error_code_t  code;
		logic [15:0]           sample;
		logic [2:0]            chan;
		logic                  last;
		logic [31:0]           rate;
		logic [3:0]            count;
	} wav_result_t;

	logic clk = 1'b0;
	logic arst_n;

	wsp_stream_if stream_ch ();
	wsp_result_if result_ch ();

	wav_stream_parser DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_ch),
		.result (result_ch)
	);

	stream_req_t bytes_to_send[$];
	wav_result_t results_due[$];
	int          mismatches = 0;
	int          cycle_count = 0;
	gap_mode_t   gap_mode = GAPS_RECEIVER_SLOW;
	bit          long_stall_req = 1'b0;
	bit          long_stall_done = 1'b0;
	int          stall_left = 0;
	int          chan_total;

	// Predicted parser state.
	parse_phase_t parse_phase = ST_PREAMBLE;
	bit           preamble_good = 1'b1;
	int           field_count = 0;
	logic [31:0]  tag_word = '0;
	logic [31:0]  bytes_left = '0;
	logic         pad_pending = 1'b0;
	int           fmt_pos = 0;
	logic [15:0]  fmt_code = '0;
	logic [15:0]  fmt_chans = '0;
	logic [31:0]  fmt_rate = '0;
	logic [15:0]  fmt_bits = '0;
	logic [7:0]   sample_low = '0;
	int           frame_pos = 0;
	logic [15:0]  frame_samples [CHAN_LIMIT];

	always #5 clk = ~clk;

	function automatic bit gap_roll(input int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	task automatic expect_result(input wsp_pkg::result_kind_t kind,
			input wsp_pkg::error_code_t code,
			input logic [15:0] sample, input logic [2:0] chan, input logic last,
			input logic [31:0] rate, input logic [3:0] count);
		wav_result_t r;
		r.kind   = kind;
		r.code   = code;
		r.sample = sample;
		r.chan   = chan;
		r.last   = last;
		r.rate   = rate;
		r.count  = count;
		results_due.push_back(r);
	endtask

	task automatic raise_error(input wsp_pkg::error_code_t code);
		parse_phase = ST_FAILED;
		expect_result(wsp_pkg::KIND_ERROR, code, '0, '0, 1'b0, '0, '0);
	endtask

	// An odd-sized chunk is followed by one pad byte.
	task automatic close_chunk();
		parse_phase = pad_pending ? ST_PAD : ST_HEADER;
	endtask

	// Advances the predicted parser by one accepted request and queues its results.
	task automatic parse_stream_byte(input wsp_pkg::action_t act, input logic [7:0] b);
		int slot;
		int c;
		if (parse_phase == ST_DONE || parse_phase == ST_FAILED)
			return;
		if (act == wsp_pkg::ACT_END) begin
			if (parse_phase == ST_DATA && frame_pos == 0) begin
				parse_phase = ST_DONE;
				expect_result(wsp_pkg::KIND_END, wsp_pkg::ERR_PROTOCOL, '0, '0, 1'b0, '0, '0);
			end else begin
				raise_error(wsp_pkg::ERR_PROTOCOL);
			end
			return;
		end
		case (parse_phase)
			ST_PREAMBLE: begin
				if (field_count < 4 && b != RIFF_WORD[31 - 8 * field_count -: 8])
					preamble_good = 1'b0;
				if (field_count >= 8 && b != WAVE_WORD[31 - 8 * (field_count - 8) -: 8])
					preamble_good = 1'b0;
				field_count++;
				if (field_count >= 12) begin
					field_count = 0;
					if (!preamble_good)
						raise_error(wsp_pkg::ERR_PROTOCOL);
					else
						parse_phase = ST_HEADER;
				end
			end
			ST_HEADER: begin
				if (field_count == 0) begin
					tag_word   = '0;
					bytes_left = '0;
				end
				// Tag is read big-endian, size little-endian.
				if (field_count < 4)
					tag_word = {tag_word[23:0], b};
				else
					bytes_left[8 * (field_count - 4) +: 8] = b;
				field_count++;
				if (field_count >= 8) begin
					field_count = 0;
					pad_pending = bytes_left[0];
					if (tag_word == FMT_WORD) begin
						if (bytes_left < FMT_BODY) begin
							raise_error(wsp_pkg::ERR_PROTOCOL);
						end else begin
							fmt_pos     = 0;
							parse_phase = ST_FMT;
						end
					end else if (tag_word == DATA_WORD) begin
						if (fmt_code != PCM_FORMAT || fmt_chans == 0 || fmt_chans > CHAN_LIMIT ||
								fmt_rate == 0 || fmt_bits != PCM_BITS) begin
							raise_error(wsp_pkg::ERR_FORMAT);
						end else begin
							frame_pos   = 0;
							parse_phase = ST_DATA;
							expect_result(wsp_pkg::KIND_HEADER, wsp_pkg::ERR_PROTOCOL, '0, '0,
								1'b0, fmt_rate, fmt_chans[3:0]);
						end
					end else if (bytes_left == 0) begin
						close_chunk();
					end else begin
						parse_phase = ST_SKIP;
					end
				end
			end
			ST_FMT: begin
				// Byte offsets inside the fmt body; the rest of the body is not used.
				case (fmt_pos)
					0:  fmt_code = {8'h00, b};
					1:  fmt_code[15:8] = b;
					2:  fmt_chans = {8'h00, b};
					3:  fmt_chans[15:8] = b;
					4:  fmt_rate = {24'h0, b};
					5:  fmt_rate[15:8] = b;
					6:  fmt_rate[23:16] = b;
					7:  fmt_rate[31:24] = b;
					14: fmt_bits = {8'h00, b};
					15: fmt_bits[15:8] = b;
					default: ;
				endcase
				if (fmt_pos < 16)
					fmt_pos++;
				bytes_left--;
				if (bytes_left == 0)
					close_chunk();
			end
			ST_SKIP: begin
				bytes_left--;
				if (bytes_left == 0)
					close_chunk();
			end
			ST_PAD: begin
				parse_phase = ST_HEADER;
			end
			default: begin
				// Little-endian samples; a full frame is released channel by channel.
				slot = frame_pos / 2;
				if (frame_pos % 2 == 0)
					sample_low = b;
				else if (slot < CHAN_LIMIT)
					frame_samples[slot] = {b, sample_low};
				frame_pos++;
				if (frame_pos >= 2 * fmt_chans) begin
					frame_pos = 0;
					for (c = 0; c < fmt_chans && c < CHAN_LIMIT; c++)
						expect_result(wsp_pkg::KIND_SAMPLE, wsp_pkg::ERR_PROTOCOL,
							frame_samples[c], c[2:0], c + 1 == fmt_chans, '0, '0);
				end
			end
		endcase
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_result();
		wav_result_t want;
		if (results_due.size() == 0) begin
			$display("%0t: unexpected result request, expected none, actual kind %0d sample %0h",
				$time, result_ch.result_kind, result_ch.sample_value);
			mismatches++;
		end else begin
			want = results_due.pop_front();
			compare_field("result_kind", 32'(want.kind), 32'(result_ch.result_kind));
			compare_field("error_code", 32'(want.code), 32'(result_ch.error_code));
			compare_field("sample_value", {16'h0, want.sample}, {16'h0, result_ch.sample_value});
			compare_field("channel_index", 32'(want.chan), 32'(result_ch.channel_index));
			compare_field("frame_end", 32'(want.last), 32'(result_ch.frame_end));
			compare_field("sample_rate", want.rate, result_ch.sample_rate);
			compare_field("channel_count", 32'(want.count), 32'(result_ch.channel_count));
		end
	endtask

	// Stimulus builders: they append requests to the send queue.
	task automatic send_byte(input logic [7:0] b);
		stream_req_t req;
		req.act = wsp_pkg::ACT_BYTE;
		req.b   = b;
		bytes_to_send.push_back(req);
	endtask

	task automatic send_end();
		stream_req_t req;
		req.act = wsp_pkg::ACT_END;
		req.b   = 8'($urandom_range(0, 255));
		bytes_to_send.push_back(req);
	endtask

	task automatic send_le(input logic [31:0] value, input int nbytes);
		int i;
		for (i = 0; i < nbytes; i++)
			send_byte(value[8 * i +: 8]);
	endtask

	task automatic send_tag(input logic [31:0] tag);
		int i;
		for (i = 3; i >= 0; i--)
			send_byte(tag[8 * i +: 8]);
	endtask

	task automatic send_fill(input int n);
		int i;
		for (i = 0; i < n; i++)
			send_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic send_chunk_head(input logic [31:0] tag, input logic [31:0] size);
		send_tag(tag);
		send_le(size, 4);
	endtask

	task automatic send_chunk(input logic [31:0] tag, input int size);
		send_chunk_head(tag, size);
		send_fill(size + size % 2);
	endtask

	task automatic send_fmt(input int size, input logic [15:0] code, input logic [15:0] chans,
			input logic [31:0] rate, input logic [15:0] bits);
		send_chunk_head(FMT_WORD, size);
		if (size >= FMT_BODY) begin
			send_le({16'h0, code}, 2);
			send_le({16'h0, chans}, 2);
			send_le(rate, 4);
			send_fill(6);
			send_le({16'h0, bits}, 2);
			send_fill(size - 16 + size % 2);
		end else begin
			send_fill(size + size % 2);
		end
	endtask

	function automatic logic [31:0] other_tag();
		logic [31:0] tag;
		tag = $urandom();
		if (tag == FMT_WORD || tag == DATA_WORD)
			tag ^= 32'h1;
		return tag;
	endfunction

	// Whole frames of random samples, with full-scale values mixed in.
	task automatic send_frames(input int min_bytes);
		int sent;
		int c;
		sent = 0;
		while (sent < min_bytes) begin
			for (c = 0; c < chan_total; c++) begin
				if ($urandom_range(0, 7) == 0)
					send_le({16'h0, SAMPLE_EXTREMES[16 * $urandom_range(0, 3) +: 16]}, 2);
				else
					send_le($urandom_range(0, 65535), 2);
			end
			sent += 2 * chan_total;
		end
	endtask

	// Stream driver: holds a request until it is taken, may idle between requests.
	always @(posedge clk or negedge arst_n) begin
		stream_req_t next_req;
		bit          idle;
		if (!arst_n) begin
			stream_ch.valid       <= 1'b0;
			stream_ch.action      <= wsp_pkg::ACT_BYTE;
			stream_ch.stream_byte <= 8'h00;
		end else begin
			if (stream_ch.valid && stream_ch.ready)
				parse_stream_byte(wsp_pkg::action_t'(stream_ch.action), stream_ch.stream_byte);
			if (!(stream_ch.valid && !stream_ch.ready)) begin
				case (gap_mode)
					GAPS_RECEIVER_SLOW: idle = gap_roll(7);
					GAPS_SENDER_SLOW:   idle = gap_roll(86);
					default:            idle = 1'b0;
				endcase
				if (bytes_to_send.size() > 0 && !idle) begin
					next_req = bytes_to_send.pop_front();
					stream_ch.valid       <= 1'b1;
					stream_ch.action      <= next_req.act;
					stream_ch.stream_byte <= next_req.b;
				end else begin
					stream_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each taken request and drives ready with stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready)
				check_result();
			if (long_stall_req && !long_stall_done) begin
				long_stall_done = 1'b1;
				stall_left      = LONG_STALL;
			end
			if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else begin
				case (gap_mode)
					GAPS_RECEIVER_SLOW: result_ch.ready <= !gap_roll(86);
					GAPS_SENDER_SLOW:   result_ch.ready <= !gap_roll(7);
					default:            result_ch.ready <= 1'b1;
				endcase
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		stream_fault_t fault;
		logic [15:0]   good_code;
		logic [15:0]   good_chans;
		logic [31:0]   good_rate;
		logic [15:0]   good_bits;
		stream_req_t   req;
		int            hdr_len;
		int            slot;
		int            i;

		arst_n                = 1'b0;
		stream_ch.valid       = 1'b0;
		stream_ch.action      = wsp_pkg::ACT_BYTE;
		stream_ch.stream_byte = 8'h00;
		result_ch.ready       = 1'b0;

		// Pick the shape of this run's stream; most runs are well formed.
		case ($urandom_range(0, 15))
			10:      fault = FAULT_PREAMBLE;
			11:      fault = FAULT_SHORT_FMT;
			12:      fault = FAULT_NO_FMT;
			13, 14:  fault = FAULT_FORMAT;
			15:      fault = FAULT_TRUNCATED;
			default: fault = FAULT_NONE;
		endcase
		chan_total = $urandom_range(0, 1) ? CHAN_LIMIT : $urandom_range(1, CHAN_LIMIT - 1);

		// Preamble, a skipped odd or even chunk and an empty chunk.
		send_tag(RIFF_WORD);
		send_le($urandom(), 4);
		send_tag(WAVE_WORD);
		send_chunk(other_tag(), $urandom_range(1, 5));
		send_chunk(other_tag(), 0);

		// A first fmt chunk with junk values, then one that overrides it.
		if (fault != FAULT_NO_FMT) begin
			send_fmt(fault == FAULT_SHORT_FMT ? $urandom_range(0, 15) : 18,
				16'($urandom()), 16'($urandom()), $urandom(), 16'($urandom()));
			good_code  = PCM_FORMAT;
			good_chans = 16'(chan_total);
			good_bits  = PCM_BITS;
			case ($urandom_range(0, 3))
				0:       good_rate = 32'd1;
				1:       good_rate = 32'hFFFF_FFFF;
				default: good_rate = $urandom_range(1, 32'hFFFF_FFFF);
			endcase
			if (fault == FAULT_FORMAT) begin
				case ($urandom_range(0, 4))
					0: good_code = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(2, 65535));
					1: good_chans = 16'd0;
					2: good_chans = 16'($urandom_range(CHAN_LIMIT + 1, 65535));
					3: good_rate = 32'd0;
					default: good_bits = $urandom_range(0, 1) ?
						16'($urandom_range(0, 15)) : 16'($urandom_range(17, 65535));
				endcase
			end
			send_fmt(17, good_code, good_chans, good_rate, good_bits);
		end
		send_chunk_head(DATA_WORD, $urandom());
		hdr_len = bytes_to_send.size();

		if (fault == FAULT_PREAMBLE) begin
			slot = $urandom_range(0, 7);
			if (slot >= 4)
				slot += 4;
			req = bytes_to_send[slot];
			req.b = req.b ^ (8'h01 << $urandom_range(0, 7));
			bytes_to_send[slot] = req;
		end
		if (fault == FAULT_TRUNCATED) begin
			req.act = wsp_pkg::ACT_END;
			req.b   = 8'($urandom_range(0, 255));
			bytes_to_send.insert($urandom_range(0, hdr_len - 1), req);
		end

		// One frame of extreme samples (full-scale, zero and minus one), then random frames.
		for (i = 0; i < chan_total; i++)
			send_le({16'h0, SAMPLE_EXTREMES[16 * (i % 4) +: 16]}, 2);
		send_frames(30);

		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (bytes_to_send.size() > 0)
			@(posedge clk);
		gap_mode = GAPS_SENDER_SLOW;
		send_frames(45);

		while (bytes_to_send.size() > 0)
			@(posedge clk);
		gap_mode       = GAPS_NONE;
		long_stall_req = 1'b1;
		send_frames(45);

		// Either a clean end on a frame boundary or an end inside a frame.
		if ($urandom_range(0, 1))
			send_fill($urandom_range(1, 2 * chan_total - 1));
		send_end();

		// Everything after the end must be dropped without results.
		for (i = 0; i < 12; i++) begin
			if ($urandom_range(0, 1))
				send_end();
			else
				send_byte(8'($urandom_range(0, 255)));
		end

		while (bytes_to_send.size() > 0 || stream_ch.valid || results_due.size() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0 && results_due.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire

FILE: wav_stream_parser.f
rtl/wsp_pkg.sv
rtl/wsp_if.sv
rtl/wsp_ctrl.sv
rtl/wsp_dp.sv
rtl/wav_stream_parser.sv
verif/tb_wav_stream_parser.sv
